// File: rtl/core/lsia_pkg.sv
// ---------------------------------------------------------------------------
// lsia_pkg: shared types for the indexed-access stack
// Operation and status codes, controller states and the command bundle.
// ---------------------------------------------------------------------------
package lsia_pkg;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_PEEK   = 2'd2,
        OP_CHANGE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } lsia_cmd_t;

endpackage

// File: rtl/core/lsia_ram.sv
// ---------------------------------------------------------------------------
// lsia_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module lsia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/lsia_ctrl.sv
// ---------------------------------------------------------------------------
// lsia_ctrl: request sequencer for the indexed-access stack
// Takes a request, then commits it once the result register is free.
// ---------------------------------------------------------------------------
module lsia_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output lsia_pkg::lsia_cmd_t cmd
);
    import lsia_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        s_ready     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                // The result register is free when empty or drained this cycle.
                cmd.commit = !m_valid_reg || m_ready;
                if (cmd.commit) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// File: rtl/core/lsia_dp.sv
// ---------------------------------------------------------------------------
// lsia_dp: datapath for the indexed-access stack
// Entry count, address and error checks, entry RAM and result register.
// ---------------------------------------------------------------------------
module lsia_dp #(
    parameter int STACK_DEPTH = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  lsia_pkg::lsia_cmd_t cmd,
    input  logic [1:0]          s_op,
    input  logic [7:0]          s_position,
    input  logic signed [31:0]  s_value,
    output logic signed [31:0]  m_data,
    output logic [1:0]          m_status,
    output logic [8:0]          m_occupancy
);
    import lsia_pkg::*;

    localparam int AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW   = $clog2(STACK_DEPTH + 1);
    localparam int CMPW = (CW > 8) ? CW : 8;

    logic [CW-1:0]       count_reg, count_next;
    op_t                 op_reg;
    logic                err_reg, err_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic signed [31:0]  value_reg;
    logic signed [31:0]  data_reg;
    logic [1:0]          status_reg;
    logic [8:0]          occ_reg;

    op_t                 op_in;
    logic [CW-1:0]       top_idx;
    logic                rd_en;
    logic                wr_en;
    logic [31:0]         rd_data;

    assign op_in   = op_t'(s_op);
    assign top_idx = count_reg - CW'(1);

    // Decode the incoming request against the current count.
    always_comb begin
        err_next = 1'b0;
        idx_next = AW'(top_idx);
        case (op_in)
            OP_PUSH: begin
                err_next = (count_reg == CW'(STACK_DEPTH));
                idx_next = AW'(count_reg);
            end
            OP_POP: begin
                err_next = (count_reg == '0);
            end
            OP_PEEK, OP_CHANGE: begin
                err_next = (CMPW'(s_position) >= CMPW'(count_reg));
                idx_next = AW'(top_idx - CW'(s_position));
            end
            default: begin
                err_next = 1'b1;
            end
        endcase
    end

    assign rd_en = cmd.capture && !err_next && (op_in != OP_PUSH);
    assign wr_en = cmd.commit && !err_reg && (op_reg == OP_PUSH || op_reg == OP_CHANGE);

    always_comb begin
        count_next = count_reg;
        if (cmd.commit && !err_reg) begin
            if (op_reg == OP_PUSH) begin
                count_next = count_reg + CW'(1);
            end else if (op_reg == OP_POP) begin
                count_next = count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= op_in;
            err_reg   <= err_next;
            idx_reg   <= idx_next;
            value_reg <= s_value;
        end
        if (cmd.commit) begin
            data_reg <= (err_reg || op_reg == OP_PUSH) ? 32'sd0 : $signed(rd_data);
            if (!err_reg) begin
                status_reg <= ST_OK;
            end else if (op_reg == OP_PUSH) begin
                status_reg <= ST_FULL;
            end else begin
                status_reg <= ST_EMPTY;
            end
            occ_reg <= 9'(count_next);
        end
    end

    lsia_ram #(
        .WIDTH(32),
        .DEPTH(STACK_DEPTH)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(idx_reg),
        .wr_data(value_reg),
        .rd_en  (rd_en),
        .rd_addr(idx_next),
        .rd_data(rd_data)
    );

    assign m_data      = data_reg;
    assign m_status    = status_reg;
    assign m_occupancy = occ_reg;

endmodule

// File: rtl/core/lifo_stack_indexed_access_top.sv
// ---------------------------------------------------------------------------
// lifo_stack_indexed_access_top: stack of signed words with indexed access
// Push, pop, peek and change on a LIFO held in a simple dual-port RAM.
// ---------------------------------------------------------------------------
// Usage:
// A request on the s_ channel carries an operation, a position counted from
// the top (0 is the top) and a value. Push stores the value on top, pop
// removes and returns the top word, peek returns the word at the position,
// and change overwrites that word and returns the one it replaced.
// Every request produces exactly one result on the m_ channel with the data
// word, a status (ok, empty or bad position, full) and the occupancy after
// the operation. Refused requests change nothing and return zero data.
// The RAM read is issued as a request is accepted and the registered read
// data is used in the execute step, when the result is loaded and any
// write is made. A new request is not taken until the current one is
// committed, because of the registered RAM read port.
// The result register separates the two channels, so a new request is
// taken while a finished result still waits. If the receiver stalls, the
// second request waits in the execute step until the result register frees.
// A synchronous reset (aresetn low) empties the stack and drops any pending
// result; the RAM contents are not cleared, since only held entries are read.
// ---------------------------------------------------------------------------
module lifo_stack_indexed_access_top #(
    parameter int STACK_DEPTH = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic [7:0]         s_position,
    input  logic signed [31:0] s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_data,
    output logic [1:0]         m_status,
    output logic [8:0]         m_occupancy
);
    import lsia_pkg::*;

    // Commands from the sequencer: capture a request, commit its result.
    lsia_cmd_t cmd;

    // The controller owns the handshakes and the result valid flag.
    lsia_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .cmd    (cmd)
    );

    // The datapath holds the count, the entry RAM and the result fields.
    lsia_dp #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .s_op       (s_op),
        .s_position (s_position),
        .s_value    (s_value),
        .m_data     (m_data),
        .m_status   (m_status),
        .m_occupancy(m_occupancy)
    );

endmodule
